/* rtl/core/lfsr_flicker_pwm_driver_macros.svh */
// Assertion macros shared by the flicker PWM driver RTL.
// Both expect clk and arst_n in scope.
`ifndef LFSR_FLICKER_PWM_DRIVER_MACROS_SVH
`define LFSR_FLICKER_PWM_DRIVER_MACROS_SVH

// same-cycle implication
`define LFPWM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFPWM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/lfpwm_pkg.sv */
package lfpwm_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_RED_SEED     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_SEED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_PERIODS = 2'd3;

	localparam logic [15:0] RED_SEED_RST      = 16'hACE1;
	localparam logic [15:0] YELLOW_SEED_RST   = 16'h0001;
	localparam logic [19:0] STARTUP_RST       = 20'd99999;
	localparam logic [7:0]  RAMP_PERIODS_RST  = 8'd7;

	localparam logic [7:0] LEVEL_MAX = 8'd255;

	typedef enum logic [1:0] {
		PH_STARTUP = 2'd0,
		PH_RAMP    = 2'd1,
		PH_FLICKER = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0] red_seed;
		logic [15:0] yellow_seed;
		logic [19:0] startup_ticks;
		logic [7:0]  ramp_extra_periods;
	} cfg_t;

	typedef struct packed {
		logic   red_pins;
		logic   yellow_pin_a;
		logic   yellow_pin_b;
		phase_t phase;
	} res_t;

	// 16-bit Fibonacci LFSR, taps 0,2,3,5, feedback into bit 15
	function automatic logic [15:0] lfsr_next(input logic [15:0] r);
		logic fb;
		fb = r[0] ^ r[2] ^ r[3] ^ r[5];
		return {fb, r[15:1]};
	endfunction

endpackage

/* rtl/core/lfpwm_cfg.sv */
module lfpwm_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [lfpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lfpwm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output lfpwm_pkg::cfg_t                     cfg
);

	lfpwm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_seed           <= lfpwm_pkg::RED_SEED_RST;
			cfg_q.yellow_seed        <= lfpwm_pkg::YELLOW_SEED_RST;
			cfg_q.startup_ticks      <= lfpwm_pkg::STARTUP_RST;
			cfg_q.ramp_extra_periods <= lfpwm_pkg::RAMP_PERIODS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lfpwm_pkg::CFG_RED_SEED:     cfg_q.red_seed <= cfg_wdata[15:0];
				lfpwm_pkg::CFG_YELLOW_SEED:  cfg_q.yellow_seed <= cfg_wdata[15:0];
				lfpwm_pkg::CFG_STARTUP:      cfg_q.startup_ticks <= cfg_wdata[19:0];
				lfpwm_pkg::CFG_RAMP_PERIODS: cfg_q.ramp_extra_periods <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/lfpwm_tick.sv */
module lfpwm_tick #(
	parameter int PWM_SPAN = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic            advance,
	input  lfpwm_pkg::cfg_t cfg,
	output lfpwm_pkg::res_t res
);

	// longest segment is the flicker low part: brightness + span
	localparam int SEG_W = $clog2(PWM_SPAN + 256);
	localparam int LEN_W = SEG_W + 1;
	localparam logic [LEN_W-1:0] SPAN_L = LEN_W'(PWM_SPAN);

	function automatic logic [LEN_W-1:0] span_minus(input logic [7:0] v);
		if (SPAN_L > LEN_W'(v))
			return SPAN_L - LEN_W'(v);
		else
			return LEN_W'(1);
	endfunction

	logic [15:0]       red_q, yel_q, n_red, n_yel;
	lfpwm_pkg::phase_t phase_q, n_phase, emit_phase;
	logic [19:0]       start_cnt_q, n_start_cnt;
	logic [SEG_W-1:0]  seg_q, n_seg;
	logic [7:0]        period_q, n_period;
	logic [7:0]        level_q, n_level;
	logic              chan_q, n_chan;
	logic              half_q, n_half;
	logic [2:0]        pins_q, n_pins;

	logic [LEN_W-1:0]  len, seg_inc;
	logic [15:0]       cur, stepped;
	logic [7:0]        bright;

	always_comb begin
		n_red       = red_q;
		n_yel       = yel_q;
		n_phase     = phase_q;
		n_start_cnt = start_cnt_q;
		n_seg       = seg_q;
		n_period    = period_q;
		n_level     = level_q;
		n_chan      = chan_q;
		n_half      = half_q;
		n_pins      = pins_q;
		emit_phase  = phase_q;
		len         = '0;
		seg_inc     = '0;
		cur         = '0;
		stepped     = '0;
		bright      = '0;

		if (advance) begin
			if (phase_q == lfpwm_pkg::PH_STARTUP && start_cnt_q >= cfg.startup_ticks) begin
				n_phase  = lfpwm_pkg::PH_RAMP;
				n_level  = '0;
				n_period = '0;
				n_half   = 1'b0;
				n_seg    = '0;
			end
			emit_phase = n_phase;
			seg_inc    = LEN_W'(n_seg) + LEN_W'(1);

			case (n_phase)
				lfpwm_pkg::PH_STARTUP: begin
					n_pins      = 3'b000;
					n_start_cnt = start_cnt_q + 20'd1;
				end
				lfpwm_pkg::PH_RAMP: begin
					len    = !n_half ? LEN_W'(n_level) + LEN_W'(1) : span_minus(n_level);
					n_pins = !n_half ? 3'b101 : 3'b000;
					if (seg_inc >= len) begin
						n_seg = '0;
						if (!n_half) begin
							n_half = 1'b1;
						end else begin
							n_half = 1'b0;
							if (n_period >= cfg.ramp_extra_periods) begin
								n_period = '0;
								if (n_level == lfpwm_pkg::LEVEL_MAX) begin
									// enter flicker: reload seeds, open a red run
									n_phase  = lfpwm_pkg::PH_FLICKER;
									stepped  = lfpwm_pkg::lfsr_next(cfg.red_seed);
									n_red    = stepped;
									n_yel    = cfg.yellow_seed;
									n_chan   = 1'b0;
									n_period = stepped[10:3];
								end else begin
									n_level = n_level + 8'd1;
								end
							end else begin
								n_period = n_period + 8'd1;
							end
						end
					end else begin
						n_seg = seg_inc[SEG_W-1:0];
					end
				end
				lfpwm_pkg::PH_FLICKER: begin
					cur    = chan_q ? yel_q : red_q;
					bright = cur[14:7];
					len    = half_q ? span_minus(bright) : LEN_W'(bright) + SPAN_L;
					if (!chan_q)
						n_pins = {pins_q[2:1], half_q};
					else
						n_pins = {half_q, half_q, pins_q[0]};
					if (seg_inc >= len) begin
						n_seg = '0;
						if (!half_q) begin
							n_half = 1'b1;
						end else if (period_q == '0) begin
							// run done: switch channel and step its register
							n_chan  = !chan_q;
							stepped = lfpwm_pkg::lfsr_next(chan_q ? red_q : yel_q);
							if (chan_q)
								n_red = stepped;
							else
								n_yel = stepped;
							n_period = stepped[10:3];
							n_half   = 1'b0;
						end else begin
							n_half   = 1'b0;
							n_period = period_q - 8'd1;
						end
					end else begin
						n_seg = seg_inc[SEG_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q       <= lfpwm_pkg::RED_SEED_RST;
			yel_q       <= lfpwm_pkg::YELLOW_SEED_RST;
			phase_q     <= lfpwm_pkg::PH_STARTUP;
			start_cnt_q <= '0;
			seg_q       <= '0;
			period_q    <= '0;
			level_q     <= '0;
			chan_q      <= 1'b0;
			half_q      <= 1'b0;
			pins_q      <= '0;
		end else if (fire) begin
			red_q       <= n_red;
			yel_q       <= n_yel;
			phase_q     <= n_phase;
			start_cnt_q <= n_start_cnt;
			seg_q       <= n_seg;
			period_q    <= n_period;
			level_q     <= n_level;
			chan_q      <= n_chan;
			half_q      <= n_half;
			pins_q      <= n_pins;
		end
	end

	assign res.red_pins     = n_pins[0];
	assign res.yellow_pin_a = n_pins[1];
	assign res.yellow_pin_b = n_pins[2];
	assign res.phase        = emit_phase;

endmodule

/* rtl/core/lfsr_flicker_pwm_driver.sv */
// Candle flicker PWM driver.
// Input channel (in_valid/in_stall, advance): each transfer is one tick; advance=1
// steps the PWM sequencer, advance=0 only reports the held pin levels and phase.
// Output channel (out_valid/out_stall): exactly one result per input transfer,
// in order: red_pins, yellow_pin_a, yellow_pin_b and phase (0 startup, 1 ramp,
// 2 flicker).
// out_valid rises once the item fires: the input register feeds the tick logic,
// which loads the output register whenever the output slot is free. Throughput
// is one tick per cycle unless stalled; the sequencer state is updated in the same
// cycle the item moves to the output register, so the next item sees it.
// Receiver stall freezes the output register; the input register then fills and
// in_stall rises, so at most two items are held inside.
// Reset loads default config (seeds 0xACE1/0x0001, 99999 startup ticks, 8 ramp
// periods per level), clears the sequencer to startup and empties both stages.
// User writes config (cfg_wr_en/cfg_index/cfg_wdata) only while idle; unenforced.
`include "lfsr_flicker_pwm_driver_macros.svh"

module lfsr_flicker_pwm_driver #(
	parameter int PWM_SPAN = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [lfpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfpwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             advance,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             red_pins,
	output logic                             yellow_pin_a,
	output logic                             yellow_pin_b,
	output logic [1:0]                       phase
);

	lfpwm_pkg::cfg_t cfg;
	lfpwm_pkg::res_t res;

	logic            s1_valid_s1, adv_s1;
	logic            out_valid_q;
	lfpwm_pkg::res_t out_q;
	logic            out_free, fire, in_xfer;
	logic            pre_flicker;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = s1_valid_s1 && out_free;
	assign in_stall = s1_valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	lfpwm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lfpwm_tick #(
		.PWM_SPAN (PWM_SPAN)
	) u_tick (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.advance (adv_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			s1_valid_s1 <= 1'b1;
		end else if (fire) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			adv_s1 <= advance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign red_pins     = out_q.red_pins;
	assign yellow_pin_a = out_q.yellow_pin_a;
	assign yellow_pin_b = out_q.yellow_pin_b;
	assign phase        = out_q.phase;

	assign pre_flicker = out_valid && phase != lfpwm_pkg::PH_FLICKER;

	// a queued tick with a free output slot must show up next cycle
	`LFPWM_ASSERT_NXT(a_s1_drains, s1_valid_s1 && out_free, out_valid, "queued tick not delivered")
	// first yellow pin only moves during flicker
	`LFPWM_ASSERT_IMP(a_ya_low, pre_flicker, !yellow_pin_a, "yellow a high before flicker")
	// red and second yellow pin share the ramp drive
	`LFPWM_ASSERT_IMP(a_ramp_pair, pre_flicker, red_pins == yellow_pin_b, "red and yellow b split")

endmodule

/* tb/sv/lfsr_flicker_pwm_driver_tb.sv */
`timescale 1ns / 1ps

module lfsr_flicker_pwm_driver_tb;

	localparam int SPAN        = 256;
	localparam int CYCLE_LIMIT = 100_000;
	localparam int PRINT_CAP   = 100;
	// holds and ticks right after reset, LSB first
	localparam bit [11:0] OPENING_TICKS = 12'b1101_1101_1100;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             cfg_wr_en = 1'b0;
	logic [lfpwm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lfpwm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic                             advance   = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             red_pins;
	logic                             yellow_pin_a;
	logic                             yellow_pin_b;
	logic [1:0]                       phase;

	lfsr_flicker_pwm_driver #(.PWM_SPAN(SPAN)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red_pins     (red_pins),
		.yellow_pin_a (yellow_pin_a),
		.yellow_pin_b (yellow_pin_b),
		.phase        (phase)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies
	logic [15:0] red_seed_cfg    = lfpwm_pkg::RED_SEED_RST;
	logic [15:0] yellow_seed_cfg = lfpwm_pkg::YELLOW_SEED_RST;
	logic [19:0] startup_len_cfg = lfpwm_pkg::STARTUP_RST;
	logic [7:0]  ramp_reps_cfg   = lfpwm_pkg::RAMP_PERIODS_RST;

	// sequencer copy
	logic [15:0]       red_lfsr    = lfpwm_pkg::RED_SEED_RST;
	logic [15:0]       yellow_lfsr = lfpwm_pkg::YELLOW_SEED_RST;
	lfpwm_pkg::phase_t cur_phase   = lfpwm_pkg::PH_STARTUP;
	logic [19:0]       startup_cnt = '0;
	logic [9:0]        seg_cnt     = '0;
	logic [7:0]        reps_left   = '0;
	logic [7:0]        ramp_level  = '0;
	logic              yellow_turn = 1'b0;
	logic              second_part = 1'b0;
	logic [2:0]        pin_state   = '0;

	bit              pending_ticks[$];
	lfpwm_pkg::res_t expected_pins_q[$];
	int   sent_cnt   = 0;
	int   done_cnt   = 0;
	int   err_cnt    = 0;
	int   cycle_cnt  = 0;

	function automatic logic [15:0] shift_taps(input logic [15:0] r);
		return {r[5] ^ r[3] ^ r[2] ^ r[0], r[15:1]};
	endfunction

	function automatic int span_left(input int v);
		return (SPAN > v) ? SPAN - v : 1;
	endfunction

	function automatic void begin_run(input logic yellow);
		logic [15:0] bits;
		yellow_turn = yellow;
		if (!yellow) begin
			red_lfsr = shift_taps(red_lfsr);
			bits = red_lfsr;
		end else begin
			yellow_lfsr = shift_taps(yellow_lfsr);
			bits = yellow_lfsr;
		end
		reps_left   = bits[10:3];
		second_part = 1'b0;
		seg_cnt     = '0;
	endfunction

	// one transfer through the sequencer: levels of the current position, then advance
	function automatic lfpwm_pkg::res_t flicker_tick(input logic adv);
		lfpwm_pkg::res_t   r;
		lfpwm_pkg::phase_t shown;
		logic [15:0]       bits;
		int                seg_len;
		shown = cur_phase;
		if (adv) begin
			if (cur_phase == lfpwm_pkg::PH_STARTUP && startup_cnt >= startup_len_cfg) begin
				cur_phase   = lfpwm_pkg::PH_RAMP;
				ramp_level  = '0;
				reps_left   = '0;
				second_part = 1'b0;
				seg_cnt     = '0;
			end
			shown = cur_phase;
			case (cur_phase)
				lfpwm_pkg::PH_STARTUP: begin
					pin_state = 3'b000;
					startup_cnt++;
				end
				lfpwm_pkg::PH_RAMP: begin
					seg_len = second_part ? span_left(ramp_level) : int'(ramp_level) + 1;
					pin_state = second_part ? 3'b000 : 3'b101;
					seg_cnt++;
					if (seg_cnt >= seg_len) begin
						seg_cnt = '0;
						if (!second_part) begin
							second_part = 1'b1;
						end else begin
							second_part = 1'b0;
							// reps_left counts up here, down in flicker
							if (reps_left >= ramp_reps_cfg) begin
								reps_left = '0;
								if (ramp_level == lfpwm_pkg::LEVEL_MAX) begin
									cur_phase   = lfpwm_pkg::PH_FLICKER;
									red_lfsr    = red_seed_cfg;
									yellow_lfsr = yellow_seed_cfg;
									begin_run(1'b0);
								end else begin
									ramp_level++;
								end
							end else begin
								reps_left++;
							end
						end
					end
				end
				default: begin
					bits = yellow_turn ? yellow_lfsr : red_lfsr;
					seg_len = second_part ? span_left(bits[14:7]) : int'(bits[14:7]) + SPAN;
					if (!yellow_turn)
						pin_state[0] = second_part;
					else
						pin_state[2:1] = {2{second_part}};
					seg_cnt++;
					if (seg_cnt >= seg_len) begin
						seg_cnt = '0;
						if (!second_part) begin
							second_part = 1'b1;
						end else if (reps_left == 0) begin
							begin_run(!yellow_turn);
						end else begin
							second_part = 1'b0;
							reps_left--;
						end
					end
				end
			endcase
		end
		r.red_pins     = pin_state[0];
		r.yellow_pin_a = pin_state[1];
		r.yellow_pin_b = pin_state[2];
		r.phase        = shown;
		return r;
	endfunction

	function automatic bit sender_rests();
		int mode;
		mode = (sent_cnt / 190) % 4;
		if (mode == 1) return $urandom_range(0, 99) < 77;
		if (mode == 3) return $urandom_range(0, 99) < 29;
		return 1'b0;
	endfunction

	function automatic bit receiver_holds();
		int mode;
		mode = (sent_cnt / 190) % 4;
		if (mode == 2) return $urandom_range(0, 99) < 77;
		if (mode == 3) return $urandom_range(0, 99) < 29;
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (err_cnt < PRINT_CAP)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("Test completed with failures");
			$finish;
		end
	end

	// tick driver
	always @(posedge clk) begin : tick_driver
		bit take;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			take = in_valid && !in_stall;
			if (take) begin
				expected_pins_q.push_back(flicker_tick(advance));
				sent_cnt++;
			end
			if (!in_valid || take) begin
				if (pending_ticks.size() != 0 && !sender_rests()) begin
					in_valid <= 1'b1;
					advance  <= pending_ticks.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// pin monitor
	always @(posedge clk) begin : pin_monitor
		lfpwm_pkg::res_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pins_q.size() == 0) begin
					report_mismatch("unexpected transfer", 1, 0);
				end else begin
					want = expected_pins_q.pop_front();
					if (red_pins !== want.red_pins)
						report_mismatch("red_pins", red_pins, want.red_pins);
					if (yellow_pin_a !== want.yellow_pin_a)
						report_mismatch("yellow_pin_a", yellow_pin_a, want.yellow_pin_a);
					if (yellow_pin_b !== want.yellow_pin_b)
						report_mismatch("yellow_pin_b", yellow_pin_b, want.yellow_pin_b);
					if (phase !== want.phase)
						report_mismatch("phase", phase, want.phase);
				end
				done_cnt++;
			end
			out_stall <= receiver_holds();
		end
	end

	task automatic write_reg(input logic [lfpwm_pkg::CFG_IDX_W-1:0] idx,
			input logic [lfpwm_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			lfpwm_pkg::CFG_RED_SEED:     red_seed_cfg    = data[15:0];
			lfpwm_pkg::CFG_YELLOW_SEED:  yellow_seed_cfg = data[15:0];
			lfpwm_pkg::CFG_STARTUP:      startup_len_cfg = data[19:0];
			lfpwm_pkg::CFG_RAMP_PERIODS: ramp_reps_cfg   = data[7:0];
			default: ;
		endcase
	endtask

	task automatic queue_ticks(input int n);
		repeat (n) pending_ticks.push_back($urandom_range(0, 9) != 0);
	endtask

	// all transfers done and results back
	task automatic settle();
		while (pending_ticks.size() != 0 || in_valid || done_cnt != sent_cnt)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		int k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < 12; k++) pending_ticks.push_back(OPENING_TICKS[k]);
		settle();

		write_reg(lfpwm_pkg::CFG_RED_SEED, 20'h00001);
		write_reg(lfpwm_pkg::CFG_YELLOW_SEED, 20'h0FFFF);
		write_reg(lfpwm_pkg::CFG_STARTUP, 20'hFFFFF);
		write_reg(lfpwm_pkg::CFG_RAMP_PERIODS, 20'd255);
		queue_ticks(120);
		settle();

		// either drop below the count or let it run into the new end
		if ($urandom_range(0, 1))
			write_reg(lfpwm_pkg::CFG_STARTUP, '0);
		else
			write_reg(lfpwm_pkg::CFG_STARTUP, startup_cnt + 20'($urandom_range(1, 6)));
		queue_ticks(200);
		settle();

		// one period per level from here, so the level steps up
		write_reg(lfpwm_pkg::CFG_RED_SEED, 20'($urandom_range(1, 65535)));
		write_reg(lfpwm_pkg::CFG_YELLOW_SEED, 20'($urandom_range(1, 65535)));
		write_reg(lfpwm_pkg::CFG_RAMP_PERIODS, '0);
		queue_ticks(420);
		settle();

		repeat (10) @(posedge clk);
		if (err_cnt == 0 && expected_pins_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
